// File: design/scccp_pkg.sv
// ----------------------------------------------------------------------------
// scccp_pkg
// Shared types and constants for the serial channel command parser.
// ----------------------------------------------------------------------------
`default_nettype none

package scccp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 3;

  localparam logic [ByteW-1:0] CH_O    = 8'h4F;
  localparam logic [ByteW-1:0] CH_S    = 8'h53;
  localparam logic [ByteW-1:0] CH_N    = 8'h4E;
  localparam logic [ByteW-1:0] CH_F    = 8'h46;
  localparam logic [ByteW-1:0] CH_T    = 8'h54;
  localparam logic [ByteW-1:0] CH_CR   = 8'h0D;
  localparam logic [ByteW-1:0] CH_LF   = 8'h0A;
  localparam logic [ByteW-1:0] CH_ZERO = 8'h30;
  localparam logic [ByteW-1:0] CH_ONE  = 8'h31;

  localparam logic [KindW-1:0] KIND_ON      = 3'd0;
  localparam logic [KindW-1:0] KIND_OFF     = 3'd1;
  localparam logic [KindW-1:0] KIND_CHECK   = 3'd2;
  localparam logic [KindW-1:0] KIND_CMD_ERR = 3'd3;
  localparam logic [KindW-1:0] KIND_OPD_ERR = 3'd4;

  typedef struct packed {
    logic             emit;
    logic [KindW-1:0] kind;
    logic             channel;
  } result_t;

endpackage

`default_nettype wire

// File: design/scccp_parser.sv
// ----------------------------------------------------------------------------
// scccp_parser
// Parser state, latched channel and per-byte result decode.
// ----------------------------------------------------------------------------
`default_nettype none

module scccp_parser (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         step,
  input  wire logic [scccp_pkg::ByteW-1:0]  rx_byte,
  output scccp_pkg::result_t                res
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_O       = 4'd1;
  localparam logic [3:0] ST_S       = 4'd2;
  localparam logic [3:0] ST_ON_DIG  = 4'd3;
  localparam logic [3:0] ST_OFF_DIG = 4'd4;
  localparam logic [3:0] ST_CHK_DIG = 4'd5;
  localparam logic [3:0] ST_ON_RDY  = 4'd6;
  localparam logic [3:0] ST_OFF_RDY = 4'd7;
  localparam logic [3:0] ST_CHK_RDY = 4'd8;
  localparam logic [3:0] ST_CMD_ERR = 4'd9;
  localparam logic [3:0] ST_OPD_ERR = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       chan_r, chan_nxt;
  logic       term, digit;

  assign term  = (rx_byte == scccp_pkg::CH_CR) || (rx_byte == scccp_pkg::CH_LF);
  assign digit = (rx_byte == scccp_pkg::CH_ZERO) || (rx_byte == scccp_pkg::CH_ONE);

  always_comb begin
    state_nxt   = state_r;
    chan_nxt    = chan_r;
    res.emit    = 1'b0;
    res.kind    = scccp_pkg::KIND_ON;
    res.channel = 1'b0;
    unique case (state_r)
      ST_O: begin
        if (rx_byte == scccp_pkg::CH_N) begin
          state_nxt = ST_ON_DIG;
        end else if (rx_byte == scccp_pkg::CH_F) begin
          state_nxt = ST_OFF_DIG;
        end else begin
          state_nxt = ST_CMD_ERR;
        end
      end
      ST_S: begin
        state_nxt = (rx_byte == scccp_pkg::CH_T) ? ST_CHK_DIG : ST_CMD_ERR;
      end
      ST_ON_DIG, ST_OFF_DIG, ST_CHK_DIG: begin
        if (digit) begin
          chan_nxt  = rx_byte[0];
          state_nxt = state_r + 4'd3;
        end else begin
          state_nxt = ST_OPD_ERR;
        end
      end
      ST_ON_RDY, ST_OFF_RDY, ST_CHK_RDY: begin
        if (term) begin
          res.emit    = 1'b1;
          res.channel = chan_r;
          res.kind    = (state_r == ST_ON_RDY)  ? scccp_pkg::KIND_ON :
                        (state_r == ST_OFF_RDY) ? scccp_pkg::KIND_OFF :
                                                  scccp_pkg::KIND_CHECK;
          state_nxt   = ST_IDLE;
        end else begin
          state_nxt = ST_OPD_ERR;
        end
      end
      ST_CMD_ERR: begin
        if (term) begin
          res.emit  = 1'b1;
          res.kind  = scccp_pkg::KIND_CMD_ERR;
          state_nxt = ST_IDLE;
        end
      end
      ST_OPD_ERR: begin
        if (term) begin
          res.emit  = 1'b1;
          res.kind  = scccp_pkg::KIND_OPD_ERR;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        // idle and unused codes
        if (rx_byte == scccp_pkg::CH_O) begin
          state_nxt = ST_O;
        end else if (rx_byte == scccp_pkg::CH_S) begin
          state_nxt = ST_S;
        end else if (term) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_CMD_ERR;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      chan_r  <= 1'b0;
    end else if (step) begin
      state_r <= state_nxt;
      chan_r  <= chan_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/serial_channel_command_parser_core.sv
// An accepted byte waits in the byte register; its result goes to the result register.
// Throughput: one item per cycle while no completing byte stalls; bytes that give no
// result never wait on out_tready. The byte register feeds the parser; a full result
// register stalls only a byte that completes a command.
// Reset: synchronous, active low; parser idle, channel zero, both stages empty.
// ----------------------------------------------------------------------------
// serial_channel_command_parser_core
// Streaming command parser: ON<d>, OF<d>, ST<d> lines ended by CR or LF.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_channel_command_parser_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] rx_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata   // [2:0] cmd_kind, [3] cmd_channel, [7:4] zero
);

  logic                                 in_valid_r;
  logic [scccp_pkg::ByteW-1:0]          in_byte_r;
  logic                                 out_valid_r;
  logic [scccp_pkg::KindW-1:0]          out_kind_r;
  logic                                 out_chan_r;
  logic                                 out_free;
  logic                                 step;
  scccp_pkg::result_t                   res;

  assign out_free  = !out_valid_r || out_tready;
  assign step      = in_valid_r && (!res.emit || out_free);
  assign in_tready = !in_valid_r || step;

  scccp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_byte_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && step && res.emit) begin
      out_kind_r <= res.kind;
      out_chan_r <= res.channel;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_chan_r, out_kind_r};

`ifndef NO_ASSERTIONS
  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.emit) |-> out_free)
    else $error("result issued while output register busy");

  a_error_chan_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == scccp_pkg::KIND_CMD_ERR ||
                     out_kind_r == scccp_pkg::KIND_OPD_ERR)) |-> !out_chan_r)
    else $error("error result carries a channel");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_kind_r <= scccp_pkg::KIND_OPD_ERR))
    else $error("result kind out of range");

  a_no_stall_without_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !res.emit) |-> in_tready)
    else $error("input stalled on an item with no result");
`endif

endmodule

`default_nettype wire

// File: sim/tb_serial_channel_command_parser_core.sv
// ----------------------------------------------------------------------------
// tb_serial_channel_command_parser_core
// Streams command lines (ON<d>, OF<d>, ST<d>) and corrupted lines into the
// parser under random input gaps and output stalls. It tracks the parse state
// and latched channel alongside the core, and checks every result item
// against the oldest pending command in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_serial_channel_command_parser_core;

  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned HoldLen    = 300;

  typedef enum logic [3:0] {
    PS_IDLE, PS_O, PS_S, PS_ON_DIG, PS_OFF_DIG, PS_CHK_DIG,
    PS_ON_RDY, PS_OFF_RDY, PS_CHK_RDY, PS_CMD_ERR, PS_OPD_ERR
  } parse_t;

  typedef struct {
    logic [scccp_pkg::KindW-1:0] kind;
    logic                        chan;
  } cmd_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;

  parse_t      parse_st = PS_IDLE;
  logic        chan_latch = 1'b0;
  cmd_t        expected_cmds[$];
  int unsigned items_sent = 0;
  int unsigned cmds_seen = 0;
  int unsigned kind_seen[8];
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;
  bit          throttle = 1'b1;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;

  serial_channel_command_parser_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!throttle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Parser tracking: advances on every accepted item, queues completed commands
  task automatic track_byte(input logic [7:0] b);
    logic term;
    term = (b == scccp_pkg::CH_CR) || (b == scccp_pkg::CH_LF);
    case (parse_st)
      PS_O: begin
        if (b == scccp_pkg::CH_N) parse_st = PS_ON_DIG;
        else if (b == scccp_pkg::CH_F) parse_st = PS_OFF_DIG;
        else parse_st = PS_CMD_ERR;
      end
      PS_S: parse_st = (b == scccp_pkg::CH_T) ? PS_CHK_DIG : PS_CMD_ERR;
      PS_ON_DIG, PS_OFF_DIG, PS_CHK_DIG: begin
        if (b == scccp_pkg::CH_ZERO || b == scccp_pkg::CH_ONE) begin
          chan_latch = (b == scccp_pkg::CH_ONE);
          case (parse_st)
            PS_ON_DIG:  parse_st = PS_ON_RDY;
            PS_OFF_DIG: parse_st = PS_OFF_RDY;
            default:    parse_st = PS_CHK_RDY;
          endcase
        end else begin
          parse_st = PS_OPD_ERR;
        end
      end
      PS_ON_RDY, PS_OFF_RDY, PS_CHK_RDY: begin
        if (term) begin
          case (parse_st)
            PS_ON_RDY:  expected_cmds.push_back('{scccp_pkg::KIND_ON, chan_latch});
            PS_OFF_RDY: expected_cmds.push_back('{scccp_pkg::KIND_OFF, chan_latch});
            default:    expected_cmds.push_back('{scccp_pkg::KIND_CHECK, chan_latch});
          endcase
          parse_st = PS_IDLE;
        end else begin
          parse_st = PS_OPD_ERR;
        end
      end
      PS_CMD_ERR: begin
        if (term) begin
          expected_cmds.push_back('{scccp_pkg::KIND_CMD_ERR, 1'b0});
          parse_st = PS_IDLE;
        end
      end
      PS_OPD_ERR: begin
        if (term) begin
          expected_cmds.push_back('{scccp_pkg::KIND_OPD_ERR, 1'b0});
          parse_st = PS_IDLE;
        end
      end
      default: begin
        if (b == scccp_pkg::CH_O) parse_st = PS_O;
        else if (b == scccp_pkg::CH_S) parse_st = PS_S;
        else if (term) parse_st = PS_IDLE;
        else parse_st = PS_CMD_ERR;
      end
    endcase
  endtask

  task automatic send_item(input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk) in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    track_byte(b);
    items_sent++;
  endtask

  task automatic send_line(input string body, input logic [7:0] term);
    foreach (body[i]) send_item(body[i]);
    send_item(term);
  endtask

  task automatic send_random_line();
    logic [7:0]  line[$];
    logic [7:0]  term;
    int unsigned n;
    term = $urandom_range(0, 1) ? scccp_pkg::CH_CR : scccp_pkg::CH_LF;
    case ($urandom_range(0, 2))
      0:       line = {scccp_pkg::CH_O, scccp_pkg::CH_N};
      1:       line = {scccp_pkg::CH_O, scccp_pkg::CH_F};
      default: line = {scccp_pkg::CH_S, scccp_pkg::CH_T};
    endcase
    line.push_back($urandom_range(0, 1) ? scccp_pkg::CH_ONE : scccp_pkg::CH_ZERO);
    if ($urandom_range(0, 99) < 25) begin
      case ($urandom_range(0, 3))
        0: line[$urandom_range(0, 2)] = 8'($urandom_range(0, 255));
        1: begin
          n = $urandom_range(0, 2);
          while (line.size() > n) void'(line.pop_back());
        end
        2: repeat ($urandom_range(1, 3)) line.push_back(8'($urandom_range(0, 255)));
        default: begin
          line.delete();
          repeat ($urandom_range(1, 5)) line.push_back(8'($urandom_range(0, 255)));
        end
      endcase
    end
    if ($urandom_range(0, 9) == 0)
      line.push_front($urandom_range(0, 1) ? scccp_pkg::CH_CR : scccp_pkg::CH_LF);
    line.push_back(term);
    foreach (line[i]) send_item(line[i]);
  endtask

  task automatic wait_drained();
    while (expected_cmds.size() != 0) @(posedge clk);
  endtask

  // Receiver: long hold on request, random short/long stalls when throttled
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HoldLen;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (throttle && $urandom_range(0, 99) < 25) begin
      stall_left = pick_gap();
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cmd_t want;
    if (rst_n && out_tvalid && out_tready) begin
      cmds_seen++;
      kind_seen[out_tdata[2:0]]++;
      if (expected_cmds.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] unexpected result: kind %0d chan %0d (tdata %h)",
                   $realtime, out_tdata[2:0], out_tdata[3], out_tdata);
      end else begin
        want = expected_cmds.pop_front();
        if (out_tdata[2:0] !== want.kind || out_tdata[3] !== want.chan ||
            out_tdata[7:4] !== 4'h0) begin
          errors++;
          if (errors <= 10)
            $display({"[%0t] mismatch: expected kind %0d chan %0d, ",
                      "got kind %0d chan %0d pad %h"},
                     $realtime, want.kind, want.chan, out_tdata[2:0], out_tdata[3],
                     out_tdata[7:4]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("timeout: no item moved for %0d cycles, %0d results pending",
                 quiet_cycles, expected_cmds.size());
        $display("tb_serial_channel_command_parser_core: FAIL");
        $finish;
      end
    end
  end

  task automatic test_directed();
    send_line("ON1", scccp_pkg::CH_CR);
    send_line("OF0", scccp_pkg::CH_LF);
    send_line("ST1", scccp_pkg::CH_CR);
    send_line("", scccp_pkg::CH_CR);
    send_line("O", scccp_pkg::CH_CR);
    send_item(scccp_pkg::CH_LF);
    send_line("ST", scccp_pkg::CH_LF);
    send_item(scccp_pkg::CH_CR);
    send_line("ON11", scccp_pkg::CH_LF);
    send_item(scccp_pkg::CH_S);
    send_item(8'hFF);
    send_item(scccp_pkg::CH_CR);
    send_item(8'h00);
    send_item(scccp_pkg::CH_LF);
    @(negedge clk) in_tvalid <= 1'b0;
    wait_drained();
  endtask

  task automatic test_random_lines();
    int unsigned stop_at;
    stop_at = items_sent + 1000;
    throttle = 1'b1;
    while (items_sent < stop_at) send_random_line();
  endtask

  task automatic test_full_rate();
    int unsigned stop_at;
    stop_at = items_sent + 250;
    throttle = 1'b0;
    while (items_sent < stop_at) send_random_line();
    throttle = 1'b1;
  endtask

  // Output held off while lines keep coming: the core must stall its input
  task automatic test_receiver_hold();
    int unsigned stop_at;
    stop_at = items_sent + 150;
    throttle = 1'b0;
    hold_req++;
    while (items_sent < stop_at) send_random_line();
    throttle = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (20) begin
      send_random_line();
      send_random_line();
      @(negedge clk) in_tvalid <= 1'b0;
      wait_drained();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    test_directed();
    test_random_lines();
    test_full_rate();
    test_receiver_hold();
    test_drain_pause();
    @(negedge clk) in_tvalid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    $display("Sent %0d bytes; checked %0d results (on %0d, off %0d, check %0d,",
             items_sent, cmds_seen, kind_seen[scccp_pkg::KIND_ON],
             kind_seen[scccp_pkg::KIND_OFF], kind_seen[scccp_pkg::KIND_CHECK]);
    $display("  command error %0d, operand error %0d), %0d mismatches",
             kind_seen[scccp_pkg::KIND_CMD_ERR], kind_seen[scccp_pkg::KIND_OPD_ERR],
             errors);
    if (errors == 0 && expected_cmds.size() == 0) begin
      $display("tb_serial_channel_command_parser_core: PASS");
    end else begin
      $display("tb_serial_channel_command_parser_core: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
